FILE: rtl/core/bpfa_pkg.sv
// Shared types and constants for the bitmap page-frame allocator.
// No dependencies; used by the controller, the datapath and the top level.
package bpfa_pkg;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OOM    = 2'd1;
    localparam logic [1:0] ST_BEYOND = 2'd2;

    typedef struct packed {
        logic wipe;
        logic load;
        logic run;
        logic post;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wipe_done;
        logic empty;
        logic fin;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/bitmap_page_frame_allocator.sv
// Bitmap first-fit page allocator, top level; depends on bpfa_pkg, bpfa_ctrl, bpfa_datapath.
// Scans one bitmap byte per cycle: n bytes up to the first byte with a clear bit (all bytes in
// use when out of memory), or the bytes of a free run inside the map.
// An accepted transaction is loaded, scanned in run and posted as a registered result; a free
// touching no byte of the map or an allocate on an empty map skips the scan and goes to post.
// A waiting result holds the next one in post. Reset wipes every byte to 0xFF, stalled.
module bitmap_page_frame_allocator #(
    parameter int MAP_BYTES_MAX = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [14:0] first_page,
    input  logic [15:0] page_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] page_index,
    output logic [1:0]  status
);

    bpfa_pkg::ctrl_cmd_t ctl;
    bpfa_pkg::ctrl_sts_t sts;

    bpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    bpfa_datapath #(
        .MAP_BYTES_MAX (MAP_BYTES_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .first_page (first_page),
        .page_count (page_count),
        .page_index (page_index),
        .status     (status)
    );

endmodule

FILE: rtl/core/bpfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bpfa_ctrl.sv
// Controller of the page allocator: sequences wipe, load, run and result posting.
// Depends on bpfa_pkg; talks to bpfa_datapath through command and status structs.
module bpfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  bpfa_pkg::ctrl_sts_t  sts,
    output bpfa_pkg::ctrl_cmd_t  ctl
);

    localparam logic [1:0] S_WIPE = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        ctl.wipe = (state_reg == S_WIPE);
        ctl.load = (state_reg == S_IDLE) && in_valid;
        ctl.run  = (state_reg == S_RUN);
        ctl.post = (state_reg == S_POST) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:
            begin
                if (sts.wipe_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.empty ? S_POST : S_RUN;
                end
            end
            S_RUN:
            begin
                if (sts.fin)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = ctl.post || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/bpfa_datapath.sv
// Datapath of the page allocator: bitmap RAM, byte pointers, masks and result registers.
// Depends on bpfa_pkg and bpfa_ram; driven by bpfa_ctrl through command and status structs.
module bpfa_datapath #(
    parameter int MAP_BYTES_MAX = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpfa_pkg::ctrl_cmd_t  ctl,
    output bpfa_pkg::ctrl_sts_t  sts,
    input  logic                 cfg_we,
    input  logic [12:0]          cfg_wdata,
    input  logic                 cmd,
    input  logic [14:0]          first_page,
    input  logic [15:0]          page_count,
    output logic [14:0]          page_index,
    output logic [1:0]           status
);

    localparam int AW      = (MAP_BYTES_MAX > 1) ? $clog2(MAP_BYTES_MAX) : 1;
    localparam int CW      = $clog2(MAP_BYTES_MAX + 1);
    localparam int XW      = (CW > 14) ? CW : 14;
    localparam int MAP_RST = (MAP_BYTES_MAX < 4096) ? MAP_BYTES_MAX : 4096;

    logic [CW-1:0] map_reg;
    logic [AW-1:0] wipe_reg;
    logic          alloc_reg;
    logic [XW-1:0] ptr_reg;
    logic [XW-1:0] end_reg;
    logic [XW-1:0] chk_reg;
    logic [XW-1:0] fbyte_reg;
    logic [XW-1:0] lbyte_reg;
    logic [2:0]    fbit_reg;
    logic [2:0]    lbit_reg;
    logic          more_reg;
    logic          pend_reg;
    logic [14:0]   res_idx_reg;
    logic [1:0]    res_st_reg;
    logic [14:0]   out_idx_reg;
    logic [1:0]    out_st_reg;

    logic [XW-1:0] mapx;
    logic [XW-1:0] fbyte;
    logic [XW-1:0] lbyte;
    logic [16:0]   lastp;
    logic          nz;
    logic          lb_out;
    logic          empty;
    logic          beyond;
    logic          issue;
    logic          full;
    logic          last;
    logic [2:0]    zbit;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [7:0]    rdata;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [XW+2:0] pidx;

    assign mapx   = XW'(map_reg);
    assign fbyte  = XW'(first_page[14:3]);
    assign lastp  = 17'(first_page) + 17'(page_count) - 17'd1;
    assign lbyte  = XW'(lastp[16:3]);
    assign nz     = (page_count != 16'd0);
    assign lb_out = (lbyte >= mapx);
    assign empty  = (cmd == bpfa_pkg::CMD_FREE) ? (!nz || (fbyte >= mapx))
                                                : (map_reg == CW'(0));
    assign beyond = (cmd == bpfa_pkg::CMD_FREE) && nz && lb_out;

    assign issue  = ctl.run && more_reg;
    assign full   = (rdata == bpfa_pkg::FULL_BYTE);
    assign last   = (chk_reg == end_reg);
    assign pidx   = {chk_reg, zbit};

    assign sts.wipe_done = (wipe_reg == AW'(MAP_BYTES_MAX - 1));
    assign sts.empty     = empty;
    assign sts.fin       = ctl.run && pend_reg && (alloc_reg ? (!full || last) : last);

    always_comb
    begin
        zbit = 3'd7;
        for (int j = 7; j >= 0; j--)
        begin
            if (!rdata[j])
            begin
                zbit = 3'(j);
            end
        end
    end

    always_comb
    begin
        lo = (chk_reg == fbyte_reg) ? fbit_reg : 3'd0;
        hi = (chk_reg == lbyte_reg) ? lbit_reg : 3'd7;
        for (int j = 0; j < 8; j++)
        begin
            mask[j] = (3'(j) >= lo) && (3'(j) <= hi);
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = chk_reg[AW-1:0];
        wdata = rdata & ~mask;
        if (ctl.wipe)
        begin
            we    = 1'b1;
            waddr = wipe_reg;
            wdata = bpfa_pkg::FULL_BYTE;
        end
        else if (ctl.run && pend_reg)
        begin
            if (alloc_reg)
            begin
                we    = !full;
                wdata = rdata | (8'd1 << zbit);
            end
            else
            begin
                we = 1'b1;
            end
        end
    end

    bpfa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg  <= CW'(MAP_RST);
            wipe_reg <= '0;
            more_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (XW'(cfg_wdata) > XW'(MAP_BYTES_MAX))
                begin
                    map_reg <= CW'(MAP_BYTES_MAX);
                end
                else
                begin
                    map_reg <= CW'(cfg_wdata);
                end
            end
            if (ctl.wipe)
            begin
                wipe_reg <= wipe_reg + AW'(1);
            end
            pend_reg <= issue;
            if (ctl.load)
            begin
                more_reg <= !empty;
            end
            else if (issue)
            begin
                more_reg <= (ptr_reg != end_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            alloc_reg   <= (cmd == bpfa_pkg::CMD_ALLOC);
            ptr_reg     <= (cmd == bpfa_pkg::CMD_FREE) ? fbyte : '0;
            if (cmd == bpfa_pkg::CMD_FREE)
            begin
                end_reg <= lb_out ? (mapx - XW'(1)) : lbyte;
            end
            else
            begin
                end_reg <= mapx - XW'(1);
            end
            fbyte_reg   <= fbyte;
            lbyte_reg   <= lbyte;
            fbit_reg    <= first_page[2:0];
            lbit_reg    <= lastp[2:0];
            res_idx_reg <= '0;
            if (cmd == bpfa_pkg::CMD_FREE)
            begin
                res_st_reg <= beyond ? bpfa_pkg::ST_BEYOND : bpfa_pkg::ST_OK;
            end
            else
            begin
                res_st_reg <= (map_reg == CW'(0)) ? bpfa_pkg::ST_OOM : bpfa_pkg::ST_OK;
            end
        end
        else
        begin
            if (issue)
            begin
                ptr_reg <= ptr_reg + XW'(1);
                chk_reg <= ptr_reg;
            end
            if (sts.fin && alloc_reg)
            begin
                if (!full)
                begin
                    res_idx_reg <= pidx[14:0];
                    res_st_reg  <= bpfa_pkg::ST_OK;
                end
                else
                begin
                    res_st_reg  <= bpfa_pkg::ST_OOM;
                end
            end
        end
        if (ctl.post)
        begin
            out_idx_reg <= res_idx_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign page_index = out_idx_reg;
    assign status     = out_st_reg;

endmodule
